/* src/bcnt_pkg.sv */
`timescale 1ns / 1ps
package bcnt_pkg;
  localparam int MAX_TRACKS = 16;
  localparam int SLOT_BITS = $clog2(MAX_TRACKS);
  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS = 8;
  localparam int POS_BITS = COORD_BITS + FRAC_BITS + 1;
  localparam int VEL_BITS = FRAC_BITS + 9;
  localparam int BOX_BITS = 4 * COORD_BITS;
  localparam int AREA_BITS = 25;
  localparam int SUM_BITS = 36;
  localparam int DIV_BITS = SUM_BITS + FRAC_BITS;
  localparam int DIV_CNT_BITS = $clog2(DIV_BITS + 1);
  localparam int LIVE_BITS = 7;
  localparam int CFG_DATA_BITS = 26;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_MIN_AREA = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_GATE = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_GAIN = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_MISSED = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_SCAN, ST_DIST, ST_CMP, ST_DECIDE, ST_SMOOTH, ST_WRITE,
    ST_FRAME, ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic scan_clear;
    logic sq_calc;
    logic cmp;
    logic scan_next;
    logic decide;
    logic smooth;
    logic write;
    logic frame;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_frame;
    logic rejected;
    logic div_done;
    logic scan_last;
    logic found;
  } ctrl_sts_t;
endpackage

/* src/bcnt_ctrl.sv */
`timescale 1ns / 1ps
module bcnt_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  bcnt_pkg::ctrl_sts_t sts,
  output bcnt_pkg::ctrl_cmd_t cmd
);
  import bcnt_pkg::*;
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_DIV;
      ST_DIV: begin
        if (sts.is_frame) state_next = ST_FRAME;
        else if (sts.rejected) state_next = ST_DONE;
        else if (sts.div_done) state_next = ST_SCAN;
      end
      ST_SCAN: state_next = ST_DIST;
      ST_DIST: state_next = ST_CMP;
      ST_CMP: state_next = sts.scan_last ? ST_DECIDE : ST_DIST;
      ST_DECIDE: state_next = sts.found ? ST_SMOOTH : ST_WRITE;
      ST_SMOOTH: state_next = ST_WRITE;
      ST_WRITE: state_next = ST_DONE;
      ST_FRAME: state_next = ST_DONE;
      ST_DONE: if (!out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_DIV: cmd.div_start = 1'b0;
      ST_SCAN: cmd.scan_clear = 1'b1;
      ST_DIST: cmd.sq_calc = 1'b1;
      ST_CMP: begin
        cmd.cmp = 1'b1;
        cmd.scan_next = 1'b1;
      end
      ST_DECIDE: cmd.decide = 1'b1;
      ST_SMOOTH: cmd.smooth = 1'b1;
      ST_WRITE: cmd.write = 1'b1;
      ST_FRAME: cmd.frame = 1'b1;
      ST_DONE: begin
        out_valid = 1'b1;
        cmd.finish = !out_stall;
      end
      default: cmd = '0;
    endcase
  end
endmodule

/* src/bcnt_datapath.sv */
`timescale 1ns / 1ps
module bcnt_datapath (
  input  logic clk,
  input  logic rst,
  input  bcnt_pkg::ctrl_cmd_t cmd,
  output bcnt_pkg::ctrl_sts_t sts,
  input  logic cfg_we,
  input  logic [bcnt_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [bcnt_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  logic req_type,
  input  logic [24:0] area,
  input  logic [35:0] sum_x,
  input  logic [35:0] sum_y,
  input  logic [11:0] min_x,
  input  logic [11:0] min_y,
  input  logic [11:0] max_x,
  input  logic [11:0] max_y,
  output logic region_accepted,
  output logic matched_existing,
  output logic table_full,
  output logic [15:0] track_number,
  output logic signed [20:0] center_x,
  output logic signed [20:0] center_y,
  output logic signed [16:0] vel_x,
  output logic signed [16:0] vel_y,
  output logic [6:0] tracks_live
);
  import bcnt_pkg::*;

  localparam int DSQ_BITS = 2 * POS_BITS + 1;
  localparam int GATE_BITS = 26 + 2 * FRAC_BITS;
  localparam logic signed [POS_BITS-1:0] POS_MAX = {1'b0, {(POS_BITS-1){1'b1}}};
  localparam logic signed [POS_BITS-1:0] POS_MIN = {1'b1, {(POS_BITS-1){1'b0}}};
  localparam logic signed [VEL_BITS-1:0] VEL_MAX = {1'b0, {(VEL_BITS-1){1'b1}}};
  localparam logic signed [VEL_BITS-1:0] VEL_MIN = {1'b1, {(VEL_BITS-1){1'b0}}};

  logic [24:0] min_area_r;
  logic [25:0] gate_r;
  logic [16:0] gain_r;
  logic [3:0] max_missed_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_area_r <= 25'd700;
      gate_r <= 26'd4900;
      gain_r <= 17'd13107;
      max_missed_r <= 4'd8;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_AREA: min_area_r <= cfg_data[24:0];
        REG_GATE: gate_r <= cfg_data;
        REG_GAIN: gain_r <= cfg_data[16:0];
        REG_MAX_MISSED: max_missed_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // track table
  logic [MAX_TRACKS-1:0] live;
  logic [15:0] ident [MAX_TRACKS];
  logic signed [POS_BITS-1:0] px [MAX_TRACKS];
  logic signed [POS_BITS-1:0] py [MAX_TRACKS];
  logic signed [VEL_BITS-1:0] vx [MAX_TRACKS];
  logic signed [VEL_BITS-1:0] vy [MAX_TRACKS];
  logic [3:0] missed [MAX_TRACKS];
  logic [BOX_BITS-1:0] box [MAX_TRACKS];
  logic [15:0] next_ident;

  // item registers
  logic is_frame_r;
  logic [24:0] area_r;
  logic [BOX_BITS-1:0] box_r;
  logic rejected_r;

  // dual restoring divider
  logic [DIV_BITS-1:0] qx, qy;
  logic [AREA_BITS:0] rx, ry;
  logic [AREA_BITS-1:0] divisor;
  logic [DIV_CNT_BITS-1:0] div_cnt;
  logic [AREA_BITS:0] rx_sh, ry_sh;

  assign rx_sh = {rx[AREA_BITS-1:0], qx[DIV_BITS-1]};
  assign ry_sh = {ry[AREA_BITS-1:0], qy[DIV_BITS-1]};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      is_frame_r <= req_type;
      area_r <= area;
      box_r <= {max_y, max_x, min_y, min_x};
      rejected_r <= (area < min_area_r) || (max_x < min_x) || (max_y < min_y);
      qx <= {sum_x, {FRAC_BITS{1'b0}}};
      qy <= {sum_y, {FRAC_BITS{1'b0}}};
      rx <= '0;
      ry <= '0;
      divisor <= (area == '0) ? AREA_BITS'(1) : area;
      div_cnt <= '0;
    end else if (div_cnt != DIV_CNT_BITS'(DIV_BITS)) begin
      div_cnt <= div_cnt + 1'b1;
      if (rx_sh >= {1'b0, divisor}) begin
        rx <= rx_sh - {1'b0, divisor};
        qx <= {qx[DIV_BITS-2:0], 1'b1};
      end else begin
        rx <= rx_sh;
        qx <= {qx[DIV_BITS-2:0], 1'b0};
      end
      if (ry_sh >= {1'b0, divisor}) begin
        ry <= ry_sh - {1'b0, divisor};
        qy <= {qy[DIV_BITS-2:0], 1'b1};
      end else begin
        ry <= ry_sh;
        qy <= {qy[DIV_BITS-2:0], 1'b0};
      end
    end
  end

  logic signed [POS_BITS-1:0] cx, cy;
  assign cx = (qx > DIV_BITS'(POS_MAX)) ? POS_MAX : qx[POS_BITS-1:0];
  assign cy = (qy > DIV_BITS'(POS_MAX)) ? POS_MAX : qy[POS_BITS-1:0];

  // nearest search, one slot at a time: squared distances registered, then compared
  logic [SLOT_BITS-1:0] idx;
  logic [GATE_BITS-1:0] best_d;
  logic [SLOT_BITS-1:0] best;
  logic found;
  logic signed [POS_BITS:0] dx, dy;
  logic [POS_BITS:0] adx, ady;
  logic [DSQ_BITS-1:0] dsq_x, dsq_y;
  logic idx_live;

  assign dx = {cx[POS_BITS-1], cx} - {px[idx][POS_BITS-1], px[idx]};
  assign dy = {cy[POS_BITS-1], cy} - {py[idx][POS_BITS-1], py[idx]};
  assign adx = dx[POS_BITS] ? POS_BITS'(0) - dx : dx;
  assign ady = dy[POS_BITS] ? POS_BITS'(0) - dy : dy;

  always_ff @(posedge clk) begin
    if (cmd.scan_clear) begin
      idx <= '0;
      best_d <= {gate_r, {(2*FRAC_BITS){1'b0}}};
      found <= 1'b0;
      best <= '0;
    end
    if (cmd.sq_calc) begin
      dsq_x <= DSQ_BITS'(adx * adx);
      dsq_y <= DSQ_BITS'(ady * ady);
      idx_live <= live[idx];
    end
    if (cmd.cmp) begin
      if (idx_live && ({1'b0, dsq_x} + {1'b0, dsq_y}) < (DSQ_BITS+1)'(best_d)) begin
        best_d <= GATE_BITS'({1'b0, dsq_x} + {1'b0, dsq_y});
        best <= idx;
        found <= 1'b1;
      end
      idx <= idx + 1'b1;
    end
  end

  // lowest free slot
  logic [SLOT_BITS-1:0] free_idx;
  logic free_any;
  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = MAX_TRACKS - 1; i >= 0; i--) begin
      if (!live[i]) begin
        free_idx = SLOT_BITS'(i);
        free_any = 1'b1;
      end
    end
  end

  // smoothing: products registered before the sum
  logic [16:0] g;
  logic [16:0] gm;
  logic signed [POS_BITS:0] nvx, nvy;
  logic signed [POS_BITS+18:0] p1x, p2x, p1y, p2y;
  logic signed [POS_BITS+19:0] sx, sy;
  logic signed [POS_BITS+3:0] fx, fy;
  logic signed [VEL_BITS-1:0] svx, svy;

  assign g = (gain_r > 17'd65536) ? 17'd65536 : gain_r;
  assign gm = 17'd65536 - g;
  assign nvx = {cx[POS_BITS-1], cx} - {px[best][POS_BITS-1], px[best]};
  assign nvy = {cy[POS_BITS-1], cy} - {py[best][POS_BITS-1], py[best]};

  always_ff @(posedge clk) begin
    if (cmd.smooth) begin
      p1x <= $signed({1'b0, gm}) * (POS_BITS+1)'(vx[best]);
      p2x <= $signed({1'b0, g}) * nvx;
      p1y <= $signed({1'b0, gm}) * (POS_BITS+1)'(vy[best]);
      p2y <= $signed({1'b0, g}) * nvy;
    end
  end

  assign sx = {p1x[POS_BITS+18], p1x} + {p2x[POS_BITS+18], p2x};
  assign sy = {p1y[POS_BITS+18], p1y} + {p2y[POS_BITS+18], p2y};
  assign fx = sx[POS_BITS+19:16];
  assign fy = sy[POS_BITS+19:16];
  assign svx = (fx > (POS_BITS+4)'(VEL_MAX)) ? VEL_MAX :
               (fx < (POS_BITS+4)'(VEL_MIN)) ? VEL_MIN : fx[VEL_BITS-1:0];
  assign svy = (fy > (POS_BITS+4)'(VEL_MAX)) ? VEL_MAX :
               (fy < (POS_BITS+4)'(VEL_MIN)) ? VEL_MIN : fy[VEL_BITS-1:0];

  // frame advance for all slots
  logic signed [POS_BITS:0] mxs [MAX_TRACKS];
  logic signed [POS_BITS:0] mys [MAX_TRACKS];
  always_comb begin
    for (int i = 0; i < MAX_TRACKS; i++) begin
      mxs[i] = {px[i][POS_BITS-1], px[i]} + (POS_BITS+1)'(vx[i]);
      mys[i] = {py[i][POS_BITS-1], py[i]} + (POS_BITS+1)'(vy[i]);
    end
  end

  logic decided_found;
  always_ff @(posedge clk) begin
    if (rst) begin
      live <= '0;
      next_ident <= 16'd1;
    end else begin
      if (cmd.frame) begin
        for (int i = 0; i < MAX_TRACKS; i++) begin
          if (live[i]) begin
            if (missed[i] > max_missed_r) begin
              live[i] <= 1'b0;
            end else begin
              px[i] <= (mxs[i] > (POS_BITS+1)'(POS_MAX)) ? POS_MAX :
                       (mxs[i] < (POS_BITS+1)'(POS_MIN)) ? POS_MIN : mxs[i][POS_BITS-1:0];
              py[i] <= (mys[i] > (POS_BITS+1)'(POS_MAX)) ? POS_MAX :
                       (mys[i] < (POS_BITS+1)'(POS_MIN)) ? POS_MIN : mys[i][POS_BITS-1:0];
              if (missed[i] != 4'd15) missed[i] <= missed[i] + 1'b1;
            end
          end
        end
      end
      if (cmd.write) begin
        if (decided_found) begin
          vx[best] <= svx;
          vy[best] <= svy;
          px[best] <= cx;
          py[best] <= cy;
          missed[best] <= '0;
          box[best] <= box_r;
        end else if (free_any) begin
          live[free_idx] <= 1'b1;
          ident[free_idx] <= next_ident;
          px[free_idx] <= cx;
          py[free_idx] <= cy;
          vx[free_idx] <= '0;
          vy[free_idx] <= '0;
          missed[free_idx] <= '0;
          box[free_idx] <= box_r;
          next_ident <= next_ident + 1'b1;
        end
      end
    end
  end

  // result register
  logic [LIVE_BITS-1:0] cnt;
  always_comb begin
    cnt = '0;
    for (int i = 0; i < MAX_TRACKS; i++) cnt = cnt + LIVE_BITS'(live[i]);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      region_accepted <= 1'b0;
      matched_existing <= 1'b0;
      table_full <= 1'b0;
      track_number <= '0;
      center_x <= '0;
      center_y <= '0;
      vel_x <= '0;
      vel_y <= '0;
    end
    if (cmd.decide) decided_found <= found;
    if (cmd.write) begin
      region_accepted <= 1'b1;
      center_x <= cx;
      center_y <= cy;
      if (decided_found) begin
        matched_existing <= 1'b1;
        track_number <= ident[best];
        vel_x <= svx;
        vel_y <= svy;
      end else if (free_any) begin
        track_number <= next_ident;
      end else begin
        table_full <= 1'b1;
      end
    end
  end

  assign tracks_live = cnt;

  assign sts.is_frame = is_frame_r;
  assign sts.rejected = rejected_r;
  assign sts.div_done = (div_cnt == DIV_CNT_BITS'(DIV_BITS));
  assign sts.scan_last = (idx == SLOT_BITS'(MAX_TRACKS - 1));
  assign sts.found = found;

  logic unused_ok;
  assign unused_ok = &{1'b0, area_r, cmd.div_start, cmd.scan_next, cmd.finish, box[0], rx, ry};
endmodule

/* src/blob_centroid_nearest_tracker_core.sv */
`timescale 1ns / 1ps
// sequence: centroid division, then a scan of all 16 slots with a distance step and a compare
// step per slot, then smoothing for a matched blob only, then the table write and result; a
// frame end goes from division to the frame advance, a rejected blob straight to the result
// throughput: one transaction at a time; the next is taken in the cycle after the result leaves
// reset: rst synchronous active high, clears the track table and loads register defaults
module blob_centroid_nearest_tracker_core (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [bcnt_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [bcnt_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  logic req_type,
  input  logic [24:0] area,
  input  logic [35:0] sum_x,
  input  logic [35:0] sum_y,
  input  logic [11:0] min_x,
  input  logic [11:0] min_y,
  input  logic [11:0] max_x,
  input  logic [11:0] max_y,
  output logic out_valid,
  input  logic out_stall,
  output logic region_accepted,
  output logic matched_existing,
  output logic table_full,
  output logic [15:0] track_number,
  output logic signed [20:0] center_x,
  output logic signed [20:0] center_y,
  output logic signed [16:0] vel_x,
  output logic signed [16:0] vel_y,
  output logic [6:0] tracks_live
);
  import bcnt_pkg::*;
  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  bcnt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
  );

  bcnt_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req_type(req_type), .area(area), .sum_x(sum_x), .sum_y(sum_y),
    .min_x(min_x), .min_y(min_y), .max_x(max_x), .max_y(max_y),
    .region_accepted(region_accepted), .matched_existing(matched_existing),
    .table_full(table_full), .track_number(track_number),
    .center_x(center_x), .center_y(center_y), .vel_x(vel_x), .vel_y(vel_y),
    .tracks_live(tracks_live)
  );
endmodule

/* src/bcnt_checker.sv */
`timescale 1ns / 1ps
module bcnt_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic region_accepted,
  input logic matched_existing,
  input logic table_full,
  input logic [6:0] tracks_live
);
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("result dropped");
  a_one_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && out_valid |-> in_stall) else $error("input taken while result pending");
  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(matched_existing && table_full)) else $error("bad flags");
  a_accept: assert property (@(posedge clk) disable iff (rst)
    out_valid && !region_accepted |-> !matched_existing && !table_full)
    else $error("flags without acceptance");
  a_live: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> tracks_live <= 7'd16) else $error("live count range");
endmodule

bind blob_centroid_nearest_tracker_core bcnt_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall),
  .region_accepted(region_accepted), .matched_existing(matched_existing),
  .table_full(table_full), .tracks_live(tracks_live)
);

/* sim/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
  import bcnt_pkg::*;

  typedef struct {
    bit        req_type;
    bit [24:0] area;
    bit [35:0] sum_x;
    bit [35:0] sum_y;
    bit [11:0] min_x;
    bit [11:0] min_y;
    bit [11:0] max_x;
    bit [11:0] max_y;
  } blob_t;

  typedef struct {
    bit        region_accepted;
    bit        matched_existing;
    bit        table_full;
    bit [15:0] track_number;
    bit [20:0] center_x;
    bit [20:0] center_y;
    bit [16:0] vel_x;
    bit [16:0] vel_y;
    bit [6:0]  tracks_live;
  } track_res_t;

  class track_scoreboard;
    bit          live[MAX_TRACKS];
    bit [15:0]   ident[MAX_TRACKS];
    longint      pos_x[MAX_TRACKS];
    longint      pos_y[MAX_TRACKS];
    longint      vel_x[MAX_TRACKS];
    longint      vel_y[MAX_TRACKS];
    int          missed[MAX_TRACKS];
    bit [15:0]   next_ident;
    longint      min_area, gate_sq, gain, max_missed;
    track_res_t  want_q[$];
    int          errors;
    int          n_rej, n_match, n_new, n_full, n_frame;

    function new();
      foreach (live[i]) live[i] = 0;
      next_ident = 1;
      min_area = 700;
      gate_sq = 4900;
      gain = 13107;
      max_missed = 8;
    endfunction

    function void set_reg(logic [CFG_IDX_BITS-1:0] idx, longint val);
      case (idx)
        REG_MIN_AREA:   min_area = val & ((64'd1 << 25) - 1);
        REG_GATE:       gate_sq = val & ((64'd1 << 26) - 1);
        REG_GAIN:       gain = val & ((64'd1 << 17) - 1);
        REG_MAX_MISSED: max_missed = val & 15;
        default: ;
      endcase
    endfunction

    function longint sat(longint v, int bits);
      longint hi;
      hi = (longint'(1) << (bits - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
    endfunction

    function longint floor16(longint v);
      if (v >= 0) return v >>> 16;
      return -(((-v) + 65535) >>> 16);
    endfunction

    function longint centroid(bit [35:0] s, bit [24:0] a);
      longint unsigned q, den;
      den = (a == 0) ? 1 : a;
      q = (longint'(s) << FRAC_BITS) / den;
      return (q > 1048575) ? 1048575 : longint'(q);
    endfunction

    function longint smooth(longint v, longint nv);
      longint g;
      g = (gain > 65536) ? 65536 : gain;
      return sat(floor16((65536 - g) * v + g * nv), VEL_BITS);
    endfunction

    function void note(blob_t b);
      track_res_t r;
      longint cx, cy, best_d, d, dx, dy;
      int best, fr, cnt;
      r = '{default: 0};
      if (b.req_type) begin
        n_frame++;
        for (int i = 0; i < MAX_TRACKS; i++) begin
          if (!live[i]) continue;
          if (missed[i] > max_missed) begin
            live[i] = 0;
            continue;
          end
          pos_x[i] = sat(pos_x[i] + vel_x[i], POS_BITS);
          pos_y[i] = sat(pos_y[i] + vel_y[i], POS_BITS);
          if (missed[i] < 15) missed[i]++;
        end
      end else if (b.area < min_area || b.max_x < b.min_x || b.max_y < b.min_y) begin
        n_rej++;
      end else begin
        cx = centroid(b.sum_x, b.area);
        cy = centroid(b.sum_y, b.area);
        best_d = gate_sq << (2 * FRAC_BITS);
        best = -1;
        r.region_accepted = 1;
        r.center_x = cx[20:0];
        r.center_y = cy[20:0];
        for (int i = 0; i < MAX_TRACKS; i++) begin
          if (!live[i]) continue;
          dx = cx - pos_x[i];
          dy = cy - pos_y[i];
          d = dx * dx + dy * dy;
          if (d < best_d) begin
            best_d = d;
            best = i;
          end
        end
        if (best >= 0) begin
          n_match++;
          vel_x[best] = smooth(vel_x[best], cx - pos_x[best]);
          vel_y[best] = smooth(vel_y[best], cy - pos_y[best]);
          pos_x[best] = cx;
          pos_y[best] = cy;
          missed[best] = 0;
          r.matched_existing = 1;
          r.track_number = ident[best];
          r.vel_x = vel_x[best][16:0];
          r.vel_y = vel_y[best][16:0];
        end else begin
          fr = -1;
          for (int i = 0; i < MAX_TRACKS; i++)
            if (!live[i] && fr < 0) fr = i;
          if (fr < 0) begin
            n_full++;
            r.table_full = 1;
          end else begin
            n_new++;
            live[fr] = 1;
            ident[fr] = next_ident;
            pos_x[fr] = cx;
            pos_y[fr] = cy;
            vel_x[fr] = 0;
            vel_y[fr] = 0;
            missed[fr] = 0;
            r.track_number = next_ident;
            next_ident = 16'(next_ident + 1);
          end
        end
      end
      cnt = 0;
      foreach (live[i]) cnt += live[i];
      r.tracks_live = 7'(cnt);
      want_q = {want_q, r};
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task cmp_field(string name, longint got, longint want);
      if (got != want) report($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task check(track_res_t g);
      track_res_t w;
      if (want_q.size() == 0) begin
        report("result transaction with nothing expected");
        return;
      end
      w = want_q.pop_front();
      cmp_field("region_accepted", g.region_accepted, w.region_accepted);
      cmp_field("matched_existing", g.matched_existing, w.matched_existing);
      cmp_field("table_full", g.table_full, w.table_full);
      cmp_field("track_number", g.track_number, w.track_number);
      cmp_field("center_x", g.center_x, w.center_x);
      cmp_field("center_y", g.center_y, w.center_y);
      cmp_field("vel_x", g.vel_x, w.vel_x);
      cmp_field("vel_y", g.vel_y, w.vel_y);
      cmp_field("tracks_live", g.tracks_live, w.tracks_live);
    endtask
  endclass

  logic clk, rst;
  logic cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;
  logic in_valid, in_stall, out_valid, out_stall;
  logic req_type;
  logic [24:0] area;
  logic [35:0] sum_x, sum_y;
  logic [11:0] min_x, min_y, max_x, max_y;
  logic region_accepted, matched_existing, table_full;
  logic [15:0] track_number;
  logic signed [20:0] center_x, center_y;
  logic signed [16:0] vel_x, vel_y;
  logic [6:0] tracks_live;

  blob_centroid_nearest_tracker_core u_dut (.*);

  track_scoreboard sb;
  bit hold_req;
  int obj_x[20], obj_y[20], obj_vx[20], obj_vy[20];

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("simulation failed");
    $finish;
  end

  // result side: random stall pattern plus one long hold-off on request
  initial begin
    int mode, hold_left, tick;
    track_res_t g;
    mode = 0;
    hold_left = 0;
    tick = 0;
    out_stall <= 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        g.region_accepted = region_accepted;
        g.matched_existing = matched_existing;
        g.table_full = table_full;
        g.track_number = track_number;
        g.center_x = center_x;
        g.center_y = center_y;
        g.vel_x = vel_x;
        g.vel_y = vel_y;
        g.tracks_live = tracks_live;
        sb.check(g);
      end
      if (hold_req) begin
        hold_req = 0;
        hold_left = 400;
      end
      tick++;
      if (tick % 150 == 0) mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1;
      end else begin
        case (mode)
          0: out_stall <= 0;
          1: out_stall <= ($urandom_range(0, 9) < 3);
          2: out_stall <= ($urandom_range(0, 9) < 7);
          default: out_stall <= (tick % 7 < 3);
        endcase
      end
    end
  end

  task send(blob_t b);
    in_valid <= 1;
    req_type <= b.req_type;
    area <= b.area;
    sum_x <= b.sum_x;
    sum_y <= b.sum_y;
    min_x <= b.min_x;
    min_y <= b.min_y;
    max_x <= b.max_x;
    max_y <= b.max_y;
    do @(posedge clk); while (in_stall);
    sb.note(b);
  endtask

  task send_gap(blob_t b, int gap);
    send(b);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task drain();
    in_valid <= 0;
    while (sb.want_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task write_reg(logic [CFG_IDX_BITS-1:0] idx, longint val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_BITS'(val);
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task set_regs(longint ma, longint gt, longint gn, longint mm);
    drain();
    write_reg(REG_MIN_AREA, ma);
    write_reg(REG_GATE, gt);
    write_reg(REG_GAIN, gn);
    write_reg(REG_MAX_MISSED, mm);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  function blob_t make_blob(int px, int py, longint a);
    blob_t b;
    int w;
    b.req_type = 0;
    b.area = 25'(a);
    b.sum_x = 36'(longint'(px) * a + longint'($urandom_range(0, 65535)) % (a == 0 ? 1 : a));
    b.sum_y = 36'(longint'(py) * a + longint'($urandom_range(0, 65535)) % (a == 0 ? 1 : a));
    w = $urandom_range(0, 40);
    b.min_x = 12'((px > w) ? px - w : 0);
    b.min_y = 12'((py > w) ? py - w : 0);
    b.max_x = 12'((px + w > 4095) ? 4095 : px + w);
    b.max_y = 12'((py + w > 4095) ? 4095 : py + w);
    return b;
  endfunction

  function blob_t frame_end();
    blob_t b;
    b = '{default: 0};
    b.req_type = 1;
    b.area = 25'($urandom);
    b.sum_x = 36'({$urandom, $urandom});
    b.sum_y = 36'({$urandom, $urandom});
    return b;
  endfunction

  function blob_t rand_item();
    blob_t b;
    int k, j;
    longint a, lo;
    k = $urandom_range(0, 99);
    if (k < 12) return frame_end();
    if (k < 20) begin
      b = frame_end();
      b.req_type = 0;
      b.area = 25'({$urandom} & 25'h1ffffff);
      if (k < 14) b.area = 25'($urandom_range(0, 3));
      b.min_x = 12'($urandom);
      b.min_y = 12'($urandom);
      b.max_x = 12'($urandom);
      b.max_y = 12'($urandom);
      return b;
    end
    lo = (sb.min_area > 16777216) ? 16777216 : sb.min_area;
    if (lo > 100000 || $urandom_range(0, 19) == 0)
      a = lo + ({$urandom} % (16777216 - lo + 1));
    else
      a = $urandom_range(0, 3000) + ((lo > 50) ? lo - 50 : 0);
    j = $urandom_range(0, 19);
    if (k < 75) begin
      b = make_blob(obj_x[j] + $urandom_range(0, 30) - 15,
                    obj_y[j] + $urandom_range(0, 30) - 15, a);
    end else begin
      b = make_blob($urandom_range(0, 4095), $urandom_range(0, 4095), a);
    end
    return b;
  endfunction

  task run_random(int n);
    int burst, gap;
    blob_t b;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) begin
        in_valid <= 0;
        drain();
      end
      if ((i % 40) == 0)
        foreach (obj_x[j]) begin
          obj_x[j] = $urandom_range(100, 3995);
          obj_y[j] = $urandom_range(100, 3995);
          obj_vx[j] = $urandom_range(0, 16) - 8;
          obj_vy[j] = $urandom_range(0, 16) - 8;
        end
      b = rand_item();
      if (b.req_type)
        foreach (obj_x[j]) begin
          obj_x[j] = (obj_x[j] + obj_vx[j]) & 12'hfff;
          obj_y[j] = (obj_y[j] + obj_vy[j]) & 12'hfff;
        end
      if (burst <= 0) begin
        burst = $urandom_range(1, 20);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
      burst--;
      send_gap(b, (burst == 0) ? gap : 0);
    end
  endtask

  initial begin
    blob_t b;
    sb = new();
    rst <= 1;
    cfg_we <= 0;
    cfg_index <= 0;
    cfg_data <= 0;
    in_valid <= 0;
    req_type <= 0;
    area <= 0;
    sum_x <= 0;
    sum_y <= 0;
    min_x <= 0;
    min_y <= 0;
    max_x <= 0;
    max_y <= 0;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed, reset settings
    send_gap(frame_end(), 0);
    send_gap(make_blob(100, 100, 699), 0);
    send_gap(make_blob(100, 100, 700), 0);
    send_gap(make_blob(110, 105, 700), 1);
    send_gap(make_blob(4095, 4095, 4096), 0);
    b = make_blob(500, 500, 800);
    b.max_x = b.min_x - 1;
    send_gap(b, 0);
    b = make_blob(600, 600, 800);
    b.max_y = b.min_y - 1;
    send_gap(b, 0);
    send_gap(make_blob(0, 0, 16777216), 0);
    for (int i = 0; i < 16; i++)
      send_gap(make_blob(200 + i * 230, 3000, 900), 0);
    send_gap(frame_end(), 0);

    set_regs(0, 33554432, 65536, 0);
    b = make_blob(0, 0, 0);
    b.sum_x = 36'hfffffffff;
    b.sum_y = 36'h123456789;
    send_gap(b, 0);
    b.area = 1;
    send_gap(b, 0);
    b.area = 25'h1ffffff;
    send_gap(b, 0);
    hold_req = 1;
    run_random(275);

    set_regs(16777216, 0, 0, 14);
    run_random(275);
    set_regs(1, 10000, 131071, 15);
    run_random(275);
    set_regs(200, 900, 40000, 3);
    run_random(275);
    set_regs(700, 4900, 13107, 8);
    run_random(275);
    set_regs(5000, 20000000, 1, 1);
    run_random(250);
    in_valid <= 0;
    drain();

    $display("covered %0d frame ends, %0d rejected, %0d new, %0d matched, %0d table full",
             sb.n_frame, sb.n_rej, sb.n_new, sb.n_match, sb.n_full);
    $display("over six register settings with random stalls on both sides");
    if (sb.errors == 0 && sb.want_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
